// ----- rtl/tbgd_pkg.sv -----
//------------------------------------------------------------------------------
// tbgd_pkg
// Shared constants, types and tables for the text box geometry decoder.
//------------------------------------------------------------------------------
package tbgd_pkg;

    localparam int MAX_MAP_DIM_DEF = 1024;
    localparam int CORDIC_STEPS    = 16;
    localparam int ZW              = 20;   // angle accumulator, Q16 radians
    localparam int XW              = 19;   // cordic x/y, Q16
    localparam logic signed [ZW-1:0] Q16_PI      = 20'sd205887;
    localparam logic signed [ZW-1:0] Q16_HALF_PI = 20'sd102944;
    localparam logic signed [ZW-1:0] Q16_TWO_PI  = 20'sd411775;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 19'sd39797;
    localparam logic signed [17:0]   DEG_SCALE   = 18'sd58671;
    localparam logic [15:0]          THRESH_RST  = 16'd32768;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30386;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            default: v = 20'sd2;
        endcase
        return v;
    endfunction

    // geometry carried alongside the cordic
    typedef struct packed {
        logic [9:0]  col;
        logic [9:0]  row;
        logic [15:0] score;
        logic [15:0] d1;
        logic [15:0] d2;
        logic [16:0] w;
        logic [16:0] h;
        logic signed [15:0] deg;
    } t_side;

endpackage

// ----- rtl/tbgd_cordic_stage.sv -----
//------------------------------------------------------------------------------
// tbgd_cordic_stage
// Two CORDIC rotation steps with registered result and side payload.
//------------------------------------------------------------------------------
module tbgd_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [tbgd_pkg::XW-1:0] i_x,
    input  logic signed [tbgd_pkg::XW-1:0] i_y,
    input  logic signed [tbgd_pkg::ZW-1:0] i_z,
    input  logic                          i_neg,
    input  tbgd_pkg::t_side               i_side,
    output logic                          o_vld,
    output logic signed [tbgd_pkg::XW-1:0] o_x,
    output logic signed [tbgd_pkg::XW-1:0] o_y,
    output logic signed [tbgd_pkg::ZW-1:0] o_z,
    output logic                          o_neg,
    output tbgd_pkg::t_side               o_side
);
    logic                          r_vld;
    logic signed [tbgd_pkg::XW-1:0] r_x, r_y, n_x, n_y, x1, y1;
    logic signed [tbgd_pkg::ZW-1:0] r_z, n_z, z1;
    logic                          r_neg;
    tbgd_pkg::t_side               r_side;

    always_comb begin
        if (i_z >= 0) begin
            x1 = i_x - (i_y >>> STEP);
            y1 = i_y + (i_x >>> STEP);
            z1 = i_z - tbgd_pkg::atan_q16(4'(STEP));
        end else begin
            x1 = i_x + (i_y >>> STEP);
            y1 = i_y - (i_x >>> STEP);
            z1 = i_z + tbgd_pkg::atan_q16(4'(STEP));
        end
        if (z1 >= 0) begin
            n_x = x1 - (y1 >>> (STEP + 1));
            n_y = y1 + (x1 >>> (STEP + 1));
            n_z = z1 - tbgd_pkg::atan_q16(4'(STEP + 1));
        end else begin
            n_x = x1 + (y1 >>> (STEP + 1));
            n_y = y1 - (x1 >>> (STEP + 1));
            n_z = z1 + tbgd_pkg::atan_q16(4'(STEP + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_neg  <= i_neg;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_neg  = r_neg;
    assign o_side = r_side;
endmodule

// ----- rtl/tbgd_front.sv -----
//------------------------------------------------------------------------------
// tbgd_front
// Input stage: score and map-bounds filter, angle reduction, sums and degree conversion.
//------------------------------------------------------------------------------
module tbgd_front #(
    parameter int MAX_MAP_DIM = tbgd_pkg::MAX_MAP_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [15:0]                   i_thresh,
    input  logic [9:0]                    i_col,
    input  logic [9:0]                    i_row,
    input  logic [15:0]                   i_score,
    input  logic [15:0]                   i_d0,
    input  logic [15:0]                   i_d1,
    input  logic [15:0]                   i_d2,
    input  logic [15:0]                   i_d3,
    input  logic signed [15:0]            i_ang,
    output logic                          o_vld,
    output logic signed [tbgd_pkg::ZW-1:0] o_z,
    output logic                          o_neg,
    output tbgd_pkg::t_side               o_side
);
    logic                          keep;
    logic signed [tbgd_pkg::ZW-1:0] z0, z1, n_z;
    logic                          n_neg;
    logic signed [34:0]            prod;
    logic signed [34:0]            dsh;
    logic                          r_vld, r_neg;
    logic signed [tbgd_pkg::ZW-1:0] r_z;
    tbgd_pkg::t_side               r_side, n_side;

    always_comb begin
        keep = (i_score >= i_thresh) && ({3'b0, i_col} < 13'(MAX_MAP_DIM))
            && ({3'b0, i_row} < 13'(MAX_MAP_DIM));
        z0 = tbgd_pkg::ZW'(i_ang) <<< 3;
        if (z0 > tbgd_pkg::Q16_PI) z1 = z0 - tbgd_pkg::Q16_TWO_PI;
        else if (z0 < -tbgd_pkg::Q16_PI) z1 = z0 + tbgd_pkg::Q16_TWO_PI;
        else z1 = z0;
        n_neg = 1'b1;
        if (z1 > tbgd_pkg::Q16_HALF_PI) n_z = tbgd_pkg::Q16_PI - z1;
        else if (z1 < -tbgd_pkg::Q16_HALF_PI) n_z = -tbgd_pkg::Q16_PI - z1;
        else begin
            n_z   = z1;
            n_neg = 1'b0;
        end
        prod = -(35'(i_ang) * 35'(tbgd_pkg::DEG_SCALE)) + 35'sd32768;
        dsh  = prod >>> 16;
        n_side.col   = i_col;
        n_side.row   = i_row;
        n_side.score = i_score;
        n_side.d1    = i_d1;
        n_side.d2    = i_d2;
        n_side.w     = {1'b0, i_d1} + {1'b0, i_d3};
        n_side.h     = {1'b0, i_d0} + {1'b0, i_d2};
        n_side.deg   = dsh[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld && keep;
        end
        if (i_en) begin
            r_z    <= n_z;
            r_neg  <= n_neg;
            r_side <= n_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_z    = r_z;
    assign o_neg  = r_neg;
    assign o_side = r_side;
endmodule

// ----- rtl/tbgd_center.sv -----
//------------------------------------------------------------------------------
// tbgd_center
// Center products (registered), sum, round and saturate.
//------------------------------------------------------------------------------
module tbgd_center (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [tbgd_pkg::XW-1:0] i_c,
    input  logic signed [tbgd_pkg::XW-1:0] i_s,
    input  tbgd_pkg::t_side               i_side,
    output logic                          o_vld,
    output logic [23:0]                   o_cx,
    output logic [23:0]                   o_cy,
    output tbgd_pkg::t_side               o_side
);
    // ax = col<<25 + c*(2d1-w) + s*(2d2-h); ay = row<<25 + c*(2d2-h) - s*(2d1-w)
    logic signed [18:0] a_w, a_h;
    logic signed [37:0] n_p0, n_p1, n_p2, n_p3;
    logic signed [37:0] r_p0, r_p1, r_p2, r_p3;
    logic               r1_vld, r2_vld;
    tbgd_pkg::t_side    r1_side, r2_side;
    logic signed [40:0] ax, ay;
    logic [23:0]        n_cx, n_cy, r_cx, r_cy;

    function automatic logic [23:0] rnd(input logic signed [40:0] a);
        logic signed [40:0] v;
        v = (a + 41'sd65536) >>> 17;
        if (v > 41'sd8388607) return 24'h7FFFFF;
        if (v < -41'sd8388608) return 24'h800000;
        return v[23:0];
    endfunction

    always_comb begin
        a_w  = 19'({1'b0, i_side.d1, 1'b0}) - 19'({1'b0, i_side.w});
        a_h  = 19'({1'b0, i_side.d2, 1'b0}) - 19'({1'b0, i_side.h});
        n_p0 = 38'(i_c) * 38'(a_w);
        n_p1 = 38'(i_s) * 38'(a_h);
        n_p2 = 38'(i_c) * 38'(a_h);
        n_p3 = 38'(i_s) * 38'(a_w);
        ax = 41'({1'b0, r1_side.col, 25'd0}) + 41'(r_p0) + 41'(r_p1);
        ay = 41'({1'b0, r1_side.row, 25'd0}) + 41'(r_p2) - 41'(r_p3);
        n_cx = rnd(ax);
        n_cy = rnd(ay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
        end
        if (i_en) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_p3 <= n_p3;
            r1_side <= i_side;
            r_cx <= n_cx;
            r_cy <= n_cy;
            r2_side <= r1_side;
        end
    end

    assign o_vld  = r2_vld;
    assign o_cx   = r_cx;
    assign o_cy   = r_cy;
    assign o_side = r2_side;
endmodule

// ----- rtl/text_box_geometry_decode.sv -----
//------------------------------------------------------------------------------
// text_box_geometry_decode
// Turns one detector map cell into a rotated text box.
//------------------------------------------------------------------------------
// Usage:
//   s_axis carries one cell per request; m_axis carries one box per cell
//   that passes the score threshold and lies inside the map. Cells that fail
//   give no output request.
//   i_cfg_we / i_cfg_wdata write the score threshold (reset 32768).
// Pipeline: one front stage, eight CORDIC stages of two rotation steps
//   each, two center stages and the output register.
// Throughput: one cell per cycle unless the output stalls; every stage
//   is a register.
// Stall: the whole pipe advances when the output register is empty or being
//   taken; s_axis_tready follows that, so nothing is lost or repeated.
// Reset: synchronous, active low; clears all valid bits and sets the
//   threshold to 32768.
//------------------------------------------------------------------------------
module text_box_geometry_decode #(
    parameter int MAX_MAP_DIM = tbgd_pkg::MAX_MAP_DIM_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // col[9:0] row[19:10] score[35:20] top[51:36] right[67:52]
    // bottom[83:68] left[99:84] angle[115:100]
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // cx[23:0] cy[47:24] width[64:48] height[81:65] deg[97:82] conf[113:98]
    output logic [119:0] m_axis_tdata
);
    localparam int NST = tbgd_pkg::CORDIC_STEPS / 2;

    logic        en;
    logic [15:0] r_thresh;
    logic        r_ovld;
    logic [119:0] r_odata;

    logic                          v [NST+1];
    logic signed [tbgd_pkg::XW-1:0] x [NST+1];
    logic signed [tbgd_pkg::XW-1:0] y [NST+1];
    logic signed [tbgd_pkg::ZW-1:0] z [NST+1];
    logic                          ng [NST+1];
    tbgd_pkg::t_side               sd [NST+1];

    logic               c_vld;
    logic [23:0]        c_cx, c_cy;
    tbgd_pkg::t_side    c_side;
    logic signed [tbgd_pkg::XW-1:0] cos_v;

    assign en = !r_ovld || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= tbgd_pkg::THRESH_RST;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_wdata;
        end
    end

    tbgd_front #(.MAX_MAP_DIM(MAX_MAP_DIM)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(s_axis_tvalid), .i_thresh(r_thresh),
        .i_col(s_axis_tdata[9:0]), .i_row(s_axis_tdata[19:10]),
        .i_score(s_axis_tdata[35:20]), .i_d0(s_axis_tdata[51:36]),
        .i_d1(s_axis_tdata[67:52]), .i_d2(s_axis_tdata[83:68]),
        .i_d3(s_axis_tdata[99:84]), .i_ang(s_axis_tdata[115:100]),
        .o_vld(v[0]), .o_z(z[0]), .o_neg(ng[0]), .o_side(sd[0])
    );
    assign x[0] = tbgd_pkg::CORDIC_GAIN;
    assign y[0] = '0;

    for (genvar g = 0; g < NST; g++) begin : g_cordic
        tbgd_cordic_stage #(.STEP(2 * g)) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_vld(v[g]), .i_x(x[g]), .i_y(y[g]), .i_z(z[g]),
            .i_neg(ng[g]), .i_side(sd[g]),
            .o_vld(v[g+1]), .o_x(x[g+1]), .o_y(y[g+1]), .o_z(z[g+1]),
            .o_neg(ng[g+1]), .o_side(sd[g+1])
        );
    end

    assign cos_v = ng[NST] ? -x[NST] : x[NST];

    tbgd_center u_center (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(v[NST]), .i_c(cos_v), .i_s(y[NST]), .i_side(sd[NST]),
        .o_vld(c_vld), .o_cx(c_cx), .o_cy(c_cy), .o_side(c_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= c_vld;
        end
        if (en) begin
            r_odata <= {6'd0, c_side.score, c_side.deg, c_side.h, c_side.w,
                        c_cy, c_cx};
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    ap_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipe stalled with empty output");
    ap_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[119:114] == 6'd0)
        else $error("pad bits set");
endmodule
